// ----- rtl/lsq_range_multilateration_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the range multilateration block
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef LSQ_RANGE_MULTILATERATION_DEFINES_SVH
`define LSQ_RANGE_MULTILATERATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSQM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSQM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lsqm_pkg.sv -----
// ----------------------------------------------------------------------------
// Range multilateration package
// Sizes, codes and the word types shared by the multilateration modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lsqm_pkg;

	localparam int MAX_LANDMARKS = 16;
	localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);
	localparam int IDX_W = $clog2(MAX_LANDMARKS);
	localparam int SW = 40;
	localparam int TW = 58;
	localparam int WW = 128;
	localparam int WCNT_W = $clog2(WW);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FEW      = 2'd1,
		ST_SINGULAR = 2'd2,
		ST_DROPPED  = 2'd3
	} lsqm_status_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_RD,
		B_ROW,
		B_WSTART,
		B_WWAIT,
		B_DSTART,
		B_DWAIT,
		B_OUT
	} lsqm_bstate_t;

	typedef enum logic {
		W_MUL,
		W_DIV
	} lsqm_wop_t;

	typedef struct packed {
		logic      start;
		lsqm_wop_t op;
	} lsqm_wcmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lsqm_wstat_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        r;
		logic               last;
		logic               store_en;
		logic [IDX_W-1:0]   idx;
		logic [CNT_W-1:0]   used;
		logic               ovf;
	} lsqm_job_t;

endpackage

`default_nettype wire

// ----- rtl/lsqm_wide.sv -----
// ----------------------------------------------------------------------------
// Wide arithmetic unit
// Bit-serial unsigned multiply (one bit of a 64-bit multiplier per cycle) and
// restoring divide (one quotient bit per cycle) on 128-bit words.
// ----------------------------------------------------------------------------
`default_nettype none

module lsqm_wide import lsqm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lsqm_wcmd_t        cmd,
	input  wire logic [WW-1:0]     a,
	input  wire logic [WW-1:0]     b,
	output lsqm_wstat_t            stat,
	output logic [WW-1:0]          result
);

	logic [WW-1:0]     acc_q;
	logic [WW-1:0]     sh_q;
	logic [WW-1:0]     opb_q;
	logic [WCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	lsqm_wop_t         op_q;
	logic [WW-1:0]     rem;
	logic              fits;

	always_comb begin
		rem = {acc_q[WW-2:0], sh_q[WW-1]};
		fits = (rem >= opb_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= W_MUL;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q <= cmd.op;
				cnt_q <= (cmd.op == W_MUL) ? WCNT_W'(WW / 2 - 1) : WCNT_W'(WW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - WCNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
			sh_q <= a;
			opb_q <= b;
		end else if (busy_q) begin
			if (op_q == W_MUL) begin
				acc_q <= {acc_q[WW-2:0], 1'b0} + (sh_q[WW/2-1] ? opb_q : '0);
				sh_q <= {sh_q[WW-2:0], 1'b0};
			end else begin
				acc_q <= fits ? (rem - opb_q) : rem;
				sh_q <= {sh_q[WW-2:0], fits};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result = (op_q == W_MUL) ? acc_q : sh_q;

endmodule

`default_nettype wire

// ----- rtl/lsqm_front.sv -----
// ----------------------------------------------------------------------------
// Multilateration front end
// Accepts landmark words, assigns store slots, tracks the fill count and the
// dropped-entry flag, and queues one job word per landmark.
// ----------------------------------------------------------------------------
`default_nettype none

module lsqm_front import lsqm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] map_x,
	input  wire logic [15:0] map_y,
	input  wire logic [15:0] range_mm,
	input  wire logic        last,
	output logic             job_wr,
	output lsqm_job_t        job,
	input  wire logic        q_full
);

	logic [CNT_W-1:0] fill_q;
	logic             ovf_q;
	logic             store_en;

	always_comb begin
		store_en = (fill_q < CNT_W'(MAX_LANDMARKS));
		job.x = map_x;
		job.y = map_y;
		job.r = range_mm;
		job.last = last;
		job.store_en = store_en;
		job.idx = fill_q[IDX_W-1:0];
		job.used = store_en ? (fill_q + CNT_W'(1)) : fill_q;
		job.ovf = ovf_q | ~store_en;
	end

	assign full = q_full;
	assign job_wr = push & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q <= 1'b0;
		end else if (job_wr) begin
			if (last) begin
				fill_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				fill_q <= job.used;
				ovf_q <= job.ovf;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lsqm_fifo.sv -----
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue of job words between the front end and the solver.
// ----------------------------------------------------------------------------
`default_nettype none

module lsqm_fifo import lsqm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire lsqm_job_t wr_data,
	output logic           full,
	input  wire logic      rd_en,
	output lsqm_job_t      rd_data,
	output logic           valid
);

	lsqm_job_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lsqm_back.sv -----
// ----------------------------------------------------------------------------
// Multilateration solver
// Holds the landmark store, accumulates the normal equations one landmark at
// a time, then forms the determinant and numerators and divides serially.
// ----------------------------------------------------------------------------
`default_nettype none

module lsqm_back import lsqm_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire lsqm_job_t    job,
	input  wire logic         job_valid,
	output logic              job_pop,
	input  wire logic         res_pop,
	output logic              res_valid,
	output logic [15:0]       pos_x,
	output logic [15:0]       pos_y,
	output logic [1:0]        status,
	output logic [4:0]        used_count
);

	lsqm_bstate_t state_q;
	lsqm_bstate_t state_d;

	logic signed [15:0] mem_x [MAX_LANDMARKS];
	logic signed [15:0] mem_y [MAX_LANDMARKS];
	logic [15:0]        mem_r [MAX_LANDMARKS];

	logic signed [15:0] xi_q, yi_q, xn_q, yn_q;
	logic [15:0]        ri_q, rn_q;
	logic [CNT_W-1:0]   used_q;
	logic               ovf_q;
	logic [IDX_W-1:0]   i_q;
	logic [3:0]         step_q;
	logic [2:0]         fstep_q;
	logic               dstep_q;

	logic signed [35:0]   b_q;
	logic signed [53:0]   prod_q;
	logic signed [SW-1:0] s00_q, s01_q, s11_q;
	logic signed [TW-1:0] t0_q, t1_q;
	logic signed [WW-1:0] det_q, nx_q, ny_q;

	lsqm_status_t       pend_stat_q;
	logic signed [15:0] pend_x_q, pend_y_q;
	lsqm_status_t       out_stat_q;
	logic [15:0]        out_x_q, out_y_q;
	logic [CNT_W-1:0]   out_used_q;
	logic               res_valid_q;

	logic signed [16:0] dx, sx, dy, sy, dd;
	logic signed [17:0] sd, a0, a1;
	logic signed [17:0] op_a;
	logic signed [35:0] op_b;
	logic               last_row;

	logic signed [63:0] fa, fb;
	logic [63:0]        mag_a, mag_b;
	logic               fneg;
	logic signed [WW-1:0] sprod, held, fin_val;
	logic signed [WW-1:0] num;
	logic [WW-1:0]      an, ad;
	logic               dneg;

	lsqm_wcmd_t  wcmd;
	lsqm_wstat_t wstat;
	logic [WW-1:0] w_a, w_b, wres;

	function automatic logic [15:0] lsqm_sat(input logic neg, input logic [WW-1:0] q);
		logic [15:0] r;
		if (neg) begin
			r = (q > WW'(32768)) ? 16'h8000 : -(q[15:0]);
		end else begin
			r = (q > WW'(32767)) ? 16'h7fff : q[15:0];
		end
		return r;
	endfunction

	lsqm_wide u_wide (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (wcmd),
		.a      (w_a),
		.b      (w_b),
		.stat   (wstat),
		.result (wres)
	);

	always_comb begin
		dx = 17'(xi_q) - 17'(xn_q);
		sx = 17'(xi_q) + 17'(xn_q);
		dy = 17'(yi_q) - 17'(yn_q);
		sy = 17'(yi_q) + 17'(yn_q);
		dd = $signed({1'b0, rn_q}) - $signed({1'b0, ri_q});
		sd = $signed({2'b00, rn_q}) + $signed({2'b00, ri_q});
		a0 = {dx, 1'b0};
		a1 = {dy, 1'b0};
		case (step_q[3:1])
			3'd0: begin op_a = 18'(dx); op_b = 36'(sx); end
			3'd1: begin op_a = 18'(dy); op_b = 36'(sy); end
			3'd2: begin op_a = 18'(dd); op_b = 36'(sd); end
			3'd3: begin op_a = a0; op_b = 36'(a0); end
			3'd4: begin op_a = a0; op_b = 36'(a1); end
			3'd5: begin op_a = a1; op_b = 36'(a1); end
			3'd6: begin op_a = a0; op_b = b_q; end
			default: begin op_a = a1; op_b = b_q; end
		endcase
		last_row = (i_q == IDX_W'(used_q - CNT_W'(1)));
	end

	always_comb begin
		case (fstep_q)
			3'd0: begin fa = 64'(s00_q); fb = 64'(s11_q); end
			3'd1: begin fa = 64'(s01_q); fb = 64'(s01_q); end
			3'd2: begin fa = 64'(s11_q); fb = 64'(t0_q); end
			3'd3: begin fa = 64'(s01_q); fb = 64'(t1_q); end
			3'd4: begin fa = 64'(s00_q); fb = 64'(t1_q); end
			default: begin fa = 64'(s01_q); fb = 64'(t0_q); end
		endcase
		mag_a = fa[63] ? -fa : fa;
		mag_b = fb[63] ? -fb : fb;
		fneg = fa[63] ^ fb[63];
		sprod = fneg ? -$signed(wres) : $signed(wres);
		case (fstep_q[2:1])
			2'd0: held = det_q;
			2'd1: held = nx_q;
			default: held = ny_q;
		endcase
		fin_val = fstep_q[0] ? (held - sprod) : sprod;
		num = dstep_q ? ny_q : nx_q;
		an = num[WW-1] ? -num : num;
		ad = det_q[WW-1] ? -det_q : det_q;
		dneg = num[WW-1] ^ det_q[WW-1];
		if (state_q == B_DSTART) begin
			w_a = (an << 1) + ad;
			w_b = ad << 1;
		end else begin
			w_a = {{(WW - 64){1'b0}}, mag_a};
			w_b = {{(WW - 64){1'b0}}, mag_b};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid && job.last) begin
					state_d = (job.used < CNT_W'(3)) ? B_OUT : B_RD;
				end
			end
			B_RD: state_d = B_ROW;
			B_ROW: begin
				if (step_q == 4'd15) begin
					state_d = last_row ? B_WSTART : B_RD;
				end
			end
			B_WSTART: state_d = B_WWAIT;
			B_WWAIT: begin
				if (wstat.done) begin
					if (fstep_q == 3'd1 && fin_val == '0) begin
						state_d = B_OUT;
					end else if (fstep_q == 3'd5) begin
						state_d = B_DSTART;
					end else begin
						state_d = B_WSTART;
					end
				end
			end
			B_DSTART: state_d = B_DWAIT;
			B_DWAIT: begin
				if (wstat.done) begin
					state_d = dstep_q ? B_OUT : B_DSTART;
				end
			end
			B_OUT: begin
				if (!res_valid_q) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		job_pop = 1'b0;
		wcmd.start = 1'b0;
		wcmd.op = W_MUL;
		unique case (state_q)
			B_IDLE: job_pop = job_valid;
			B_WSTART: wcmd.start = 1'b1;
			B_DSTART: begin
				wcmd.start = 1'b1;
				wcmd.op = W_DIV;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_OUT && !res_valid_q) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop && job.store_en) begin
			mem_x[job.idx] <= job.x;
			mem_y[job.idx] <= job.y;
			mem_r[job.idx] <= job.r;
		end
		if (state_q == B_RD) begin
			xi_q <= mem_x[i_q];
			yi_q <= mem_y[i_q];
			ri_q <= mem_r[i_q];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (job_pop && job.last) begin
					xn_q <= job.x;
					yn_q <= job.y;
					rn_q <= job.r;
					used_q <= job.used;
					ovf_q <= job.ovf;
					i_q <= '0;
					fstep_q <= 3'd0;
					dstep_q <= 1'b0;
					s00_q <= '0;
					s01_q <= '0;
					s11_q <= '0;
					t0_q <= '0;
					t1_q <= '0;
					pend_stat_q <= ST_FEW;
					pend_x_q <= '0;
					pend_y_q <= '0;
				end
			end
			B_RD: step_q <= 4'd0;
			B_ROW: begin
				step_q <= step_q + 4'd1;
				if (!step_q[0]) begin
					prod_q <= op_a * op_b;
				end else begin
					case (step_q[3:1]) inside
						3'd0: b_q <= prod_q[35:0];
						3'd1, 3'd2: b_q <= b_q + prod_q[35:0];
						3'd3: s00_q <= s00_q + prod_q[SW-1:0];
						3'd4: s01_q <= s01_q + prod_q[SW-1:0];
						3'd5: s11_q <= s11_q + prod_q[SW-1:0];
						3'd6: t0_q <= t0_q + TW'(prod_q);
						default: t1_q <= t1_q + TW'(prod_q);
					endcase
				end
				if (step_q == 4'd15 && !last_row) begin
					i_q <= i_q + IDX_W'(1);
				end
			end
			B_WWAIT: begin
				if (wstat.done) begin
					fstep_q <= fstep_q + 3'd1;
					case (fstep_q[2:1])
						2'd0: det_q <= fin_val;
						2'd1: nx_q <= fin_val;
						default: ny_q <= fin_val;
					endcase
					if (fstep_q == 3'd1 && fin_val == '0) begin
						pend_stat_q <= ST_SINGULAR;
					end
				end
			end
			B_DWAIT: begin
				if (wstat.done) begin
					dstep_q <= 1'b1;
					if (dstep_q) begin
						pend_y_q <= lsqm_sat(dneg, wres);
						pend_stat_q <= ovf_q ? ST_DROPPED : ST_OK;
					end else begin
						pend_x_q <= lsqm_sat(dneg, wres);
					end
				end
			end
			B_OUT: begin
				if (!res_valid_q) begin
					out_stat_q <= pend_stat_q;
					out_x_q <= pend_x_q;
					out_y_q <= pend_y_q;
					out_used_q <= used_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign pos_x = out_x_q;
	assign pos_y = out_y_q;
	assign status = out_stat_q;
	assign used_count = (32'(out_used_q) > 32'd31) ? 5'd31 : 5'(out_used_q);

endmodule

`default_nettype wire

// ----- rtl/lsq_range_multilateration.sv -----
// ----------------------------------------------------------------------------
// Least-squares range multilateration
// Solves a 2-D position from map landmarks and their measured ranges.
// ----------------------------------------------------------------------------
// Landmark words enter through a queue-style port: a word is taken on a
// rising edge with push high and full low. The word with last set closes the
// set, serves as the reference and starts a solve; up to 16 landmarks are
// kept; any beyond that are dropped, and a solved set flags them in status.
// A landmark word without last passes through the front end into the job
// queue and is stored when the idle solver pops it; the two-entry queue
// lets the front keep accepting words while a solve runs, and full rises
// only when that queue is full. A solve forms the normal-equation rows for
// each stored landmark, then runs six 64-bit serial products and two
// serial divides. Sets with fewer than three landmarks skip the solve and
// go straight to the output register; a zero determinant ends a solve early.
// The result word waits in an output register while empty is low and is
// taken on an edge with pop high; while it waits the solver holds its next
// result and the job queue keeps filling.
// Reset clears the fill count, the drop flag, the queue and the result valid
// flag; the landmark store and the result word itself are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lsq_range_multilateration import lsqm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] map_x,
	input  wire logic [15:0] map_y,
	input  wire logic [15:0] range_mm,
	input  wire logic        last,
	input  wire logic        pop,
	output logic             empty,
	output logic [15:0]      pos_x,
	output logic [15:0]      pos_y,
	output logic [1:0]       status,
	output logic [4:0]       used_count
);

	logic      job_wr;
	lsqm_job_t job_in;
	logic      q_full;
	logic      job_pop;
	lsqm_job_t job_out;
	logic      job_valid;
	logic      res_valid;

	lsqm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.map_x    (map_x),
		.map_y    (map_y),
		.range_mm (range_mm),
		.last     (last),
		.job_wr   (job_wr),
		.job      (job_in),
		.q_full   (q_full)
	);

	lsqm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_wr),
		.wr_data (job_in),
		.full    (q_full),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.valid   (job_valid)
	);

	lsqm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job_out),
		.job_valid  (job_valid),
		.job_pop    (job_pop),
		.res_pop    (pop),
		.res_valid  (res_valid),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.status     (status),
		.used_count (used_count)
	);

	assign empty = ~res_valid;

endmodule

`default_nettype wire

// ----- rtl/lsqm_checker.sv -----
// ----------------------------------------------------------------------------
// Multilateration port checker
// Checks that a waiting result word holds and meets the port status rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lsq_range_multilateration_defines.svh"

module lsqm_checker import lsqm_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pop,
	input wire logic        empty,
	input wire logic [15:0] pos_x,
	input wire logic [15:0] pos_y,
	input wire logic [1:0]  status,
	input wire logic [4:0]  used_count
);

	`LSQM_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(pos_x) && $stable(pos_y) && $stable(status) && $stable(used_count), "result word changed while stalled")
	`LSQM_ASSERT_IMPL(a_few_word, !empty && status == ST_FEW, pos_x == 16'd0 && pos_y == 16'd0 && used_count < 5'd3, "short set word is wrong")
	`LSQM_ASSERT_IMPL(a_solve_count, !empty && status != ST_FEW, used_count >= 5'd3, "solve with fewer than three landmarks")
	`LSQM_ASSERT_IMPL(a_sing_word, !empty && status == ST_SINGULAR, pos_x == 16'd0 && pos_y == 16'd0, "singular word has a position")

endmodule

bind lsq_range_multilateration lsqm_checker u_chk (.*);

`default_nettype wire
